[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/scta_pkg.sv]
// Package with the shared types, scan code constants and keymap tables of the translator.
`default_nettype none

package scta_pkg;

	localparam int FIFO_DEPTH_DEF = 256;

	// Set-1 make codes that the translator handles itself.
	localparam logic [7:0] SC_ESC    = 8'h01;
	localparam logic [7:0] SC_LCTRL  = 8'h1d;
	localparam logic [7:0] SC_LSHIFT = 8'h2a;
	localparam logic [7:0] SC_RSHIFT = 8'h36;
	localparam logic [7:0] SC_CAPS   = 8'h3a;
	localparam logic [7:0] SC_RCTRL  = 8'h5a;

	// Set-1 break codes of the modifier keys.
	localparam logic [7:0] SC_LCTRL_REL  = 8'h9d;
	localparam logic [7:0] SC_LSHIFT_REL = 8'haa;
	localparam logic [7:0] SC_RSHIFT_REL = 8'hb6;
	localparam logic [7:0] SC_CAPS_REL   = 8'hba;
	localparam logic [7:0] SC_RCTRL_REL  = 8'hda;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam int         KEYMAP_LEN = 54;

	localparam logic [7:0] PLAIN_MAP [KEYMAP_LEN] = '{
		8'h20, 8'h20, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h20,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h20, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
		8'h6d, 8'h2c, 8'h2e, 8'h2f
	};

	localparam logic [7:0] SHIFTED_MAP [KEYMAP_LEN] = '{
		8'h20, 8'h20, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
		8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h20,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h20, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
		8'h4d, 8'h3c, 8'h3e, 8'h3f
	};

	// Translation of one make code; shifted selects the shifted keymap table.
	function automatic logic [7:0] keymap_lookup(input logic shifted, input logic [6:0] code);
		logic [7:0] ch;
		ch = CHAR_SPACE;
		if (code < 7'(KEYMAP_LEN)) begin
			ch = shifted ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
		end
		return ch;
	endfunction

	typedef struct packed {
		logic       is_char;
		logic       power_off;
		logic [7:0] ch;
	} key_evt_t;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic caps;
	} mod_flags_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} ctrl_state_t;

endpackage

`default_nettype wire

[hw/rtl/scta_char_mem.sv]
// Character FIFO storage: one write port and one registered read port.
`default_nettype none

module scta_char_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/scta_keys.sv]
// Modifier key state and decode of one scan code into a keyboard event.
`default_nettype none

module scta_keys import scta_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       upd,
	input  wire logic [7:0] key_code,
	output key_evt_t        evt,
	output mod_flags_t      mods_nxt
);

	logic lshift_q, rshift_q, lctrl_q, rctrl_q, caps_q;
	logic lshift_d, rshift_d, lctrl_d, rctrl_d, caps_d;
	logic shifted;

	assign shifted = (lshift_q | rshift_q) ^ caps_q;

	always_comb begin
		evt       = '0;
		evt.ch    = keymap_lookup(shifted, key_code[6:0]);
		lshift_d  = lshift_q;
		rshift_d  = rshift_q;
		lctrl_d   = lctrl_q;
		rctrl_d   = rctrl_q;
		caps_d    = caps_q;
		if (!key_code[7]) begin
			case (key_code)
				SC_ESC:    evt.power_off = 1'b1;
				SC_LCTRL:  lctrl_d = 1'b1;
				SC_LSHIFT: lshift_d = 1'b1;
				SC_RSHIFT: rshift_d = 1'b1;
				SC_CAPS:   ;
				SC_RCTRL:  rctrl_d = 1'b1;
				default:   evt.is_char = 1'b1;
			endcase
		end else begin
			case (key_code)
				SC_LCTRL_REL:  lctrl_d = 1'b0;
				SC_LSHIFT_REL: lshift_d = 1'b0;
				SC_RSHIFT_REL: rshift_d = 1'b0;
				SC_CAPS_REL:   caps_d = ~caps_q;
				SC_RCTRL_REL:  rctrl_d = 1'b0;
				default:       ;
			endcase
		end
		if (!upd) begin
			lshift_d = lshift_q;
			rshift_d = rshift_q;
			lctrl_d  = lctrl_q;
			rctrl_d  = rctrl_q;
			caps_d   = caps_q;
		end
		mods_nxt.shift = lshift_d | rshift_d;
		mods_nxt.ctrl  = lctrl_d | rctrl_d;
		mods_nxt.caps  = caps_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			lctrl_q  <= 1'b0;
			rctrl_q  <= 1'b0;
			caps_q   <= 1'b0;
		end else begin
			lshift_q <= lshift_d;
			rshift_q <= rshift_d;
			lctrl_q  <= lctrl_d;
			rctrl_q  <= rctrl_d;
			caps_q   <= caps_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/scancode_to_ascii_fifo.sv]
// Top level of the set-1 scan code to ASCII translator with its character FIFO.
`default_nettype none
`include "assert_macros.svh"

// Each input transaction is either a scan code (req_type 0) or a read request
// (req_type 1), and each yields exactly one output transaction. For scan codes
// and empty reads the result is registered at the accepting edge. A read that
// pops a character waits in ST_READ, because the character store is a
// synchronous memory with a registered read port; the block takes no new
// input while in ST_READ. A new input is also held off while the output
// register holds a result that the consumer has not yet taken, unless it is
// taken in the same cycle. The FIFO holds at most FIFO_DEPTH-1 characters; a
// character that finds it full is discarded and the result shows dropped. The
// escape key raises power_off and stores nothing. The modifier flags on every
// result reflect the keyboard state after that transaction.

module scancode_to_ascii_fifo import scta_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       req_type,
	input  wire logic [7:0] key_code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            char_valid,
	output logic      [7:0] char_value,
	output logic            power_off,
	output logic            dropped,
	output logic            shift_active,
	output logic            ctrl_active,
	output logic            caps_active
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	ctrl_state_t state_q, state_d;

	logic [PTR_W-1:0] rptr_q, wptr_q, rptr_nxt, wptr_nxt;
	logic             in_acc, key_upd, empty, full, push, drop, pop;
	key_evt_t         evt;
	mod_flags_t       mods_nxt;
	logic [7:0]       rd_data;

	logic       out_valid_q;
	logic       char_valid_q;
	logic [7:0] char_value_q;
	logic       power_off_q;
	logic       dropped_q;
	mod_flags_t mods_q;

	// Pointers wrap explicitly so that any depth in range works, not only powers of two.
	assign rptr_nxt = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	assign wptr_nxt = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign empty    = (rptr_q == wptr_q);
	assign full     = (wptr_nxt == rptr_q);

	assign in_acc  = in_valid && in_ready;
	assign key_upd = in_acc && !req_type;

	scta_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (key_upd),
		.key_code  (key_code),
		.evt       (evt),
		.mods_nxt  (mods_nxt)
	);

	scta_char_mem #(
		.DEPTH (FIFO_DEPTH),
		.AW    (PTR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (wptr_q),
		.wr_data (evt.ch),
		.rd_en   (pop),
		.rd_addr (rptr_q),
		.rd_data (rd_data)
	);

	// Next state and handshake. A popping read parks in ST_READ for the memory cycle.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		drop     = 1'b0;
		pop      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					if (req_type) begin
						pop = !empty;
					end else begin
						push = evt.is_char && !full;
						drop = evt.is_char && full;
					end
				end
				if (pop) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			wptr_q <= '0;
		end else begin
			if (pop) begin
				rptr_q <= rptr_nxt;
			end
			if (push) begin
				wptr_q <= wptr_nxt;
			end
		end
	end

	// Output register: loaded at the accepting edge, or in ST_READ with memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && !pop) || state_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			char_valid_q <= 1'b1;
			char_value_q <= rd_data;
			power_off_q  <= 1'b0;
			dropped_q    <= 1'b0;
			mods_q       <= mods_nxt;
		end else if (in_acc && !pop) begin
			char_valid_q <= 1'b0;
			char_value_q <= '0;
			power_off_q  <= !req_type && evt.power_off;
			dropped_q    <= drop;
			mods_q       <= mods_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_valid   = char_valid_q;
	assign char_value   = char_value_q;
	assign power_off    = power_off_q;
	assign dropped      = dropped_q;
	assign shift_active = mods_q.shift;
	assign ctrl_active  = mods_q.ctrl;
	assign caps_active  = mods_q.caps;

	`ASSERT_CLK(a_pop_enters_read, pop |=> state_q == ST_READ && !out_valid_q, "bad read wait")
	`ASSERT_CLK(a_push_keeps_gap, push |=> wptr_q != rptr_q, "write pointer met read pointer")
	`ASSERT_NEVER(a_no_input_in_read, state_q == ST_READ && in_ready, "input taken during a read")
	`ASSERT_NEVER(a_push_and_pop, push && pop, "push and pop in the same transaction")

endmodule

`default_nettype wire

[verif/tb_scancode_to_ascii_fifo.sv]
// Self-checking testbench for the set-1 scan code to ASCII translator and its character FIFO.
`default_nettype none

module tb_scancode_to_ascii_fifo;
	import scta_pkg::*;

	// The request kinds that share the input channel.
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam int FIFO_DEPTH = FIFO_DEPTH_DEF;
	// One slot always stays empty, so the FIFO holds one character less than its depth.
	localparam int FIFO_CAPACITY = FIFO_DEPTH - 1;

	// Cycles with no transaction on either channel before the run is declared hung.
	// It lies far beyond the longest stall on either side in any correct run.
	localparam int WATCHDOG_LIMIT = 5000;
	// Quiet cycles after the last result, enough to catch any stray extra result.
	localparam int DRAIN_CYCLES = 10;

	// Keymap written out independently of the RTL package, so that a typo in the
	// package tables shows up as a mismatch. Index is the make code.
	localparam int KEY_COUNT = 54;
	localparam logic [7:0] PLAIN_KEYS [KEY_COUNT] = '{
		8'h20, 8'h20, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h20,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h20, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
		8'h6d, 8'h2c, 8'h2e, 8'h2f
	};
	localparam logic [7:0] SHIFTED_KEYS [KEY_COUNT] = '{
		8'h20, 8'h20, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
		8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h20,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h20, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
		8'h4d, 8'h3c, 8'h3e, 8'h3f
	};

	// Every code that the block treats specially, used to bias the random stimulus
	// toward modifier traffic so that shift, ctrl and caps states are well exercised.
	localparam int MOD_COUNT = 12;
	localparam logic [7:0] MOD_CODES [MOD_COUNT] = '{
		SC_ESC, SC_LCTRL, SC_LSHIFT, SC_RSHIFT, SC_CAPS, SC_RCTRL,
		SC_LCTRL_REL, SC_LSHIFT_REL, SC_RSHIFT_REL, SC_CAPS_REL, SC_RCTRL_REL,
		SC_CAPS_REL
	};

	typedef struct packed {
		logic       rt;
		logic [7:0] code;
	} key_req_t;

	typedef struct packed {
		logic       ch_ok;
		logic [7:0] ch;
		logic       poff;
		logic       drop;
		logic       shift;
		logic       ctrl;
		logic       caps;
	} key_result_t;

	// Ports of the block. Inputs start at known values before the first edge.
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       req_type  = 1'b0;
	logic [7:0] key_code  = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       char_valid;
	logic [7:0] char_value;
	logic       power_off;
	logic       dropped;
	logic       shift_active;
	logic       ctrl_active;
	logic       caps_active;

	// Keyboard state as the testbench expects it to be inside the block.
	logic lshift_held = 1'b0;
	logic rshift_held = 1'b0;
	logic lctrl_held  = 1'b0;
	logic rctrl_held  = 1'b0;
	logic caps_on     = 1'b0;
	logic [7:0] char_model [$];

	key_req_t    pending_keys [$];
	key_result_t expected_results [$];

	int unsigned gap_left    = 0;
	int unsigned quiet_in    = 0;
	int unsigned stall_left  = 0;
	int unsigned quiet_out   = 0;
	int unsigned idle_cycles = 0;
	int unsigned results_seen = 0;
	int unsigned error_count  = 0;

	scancode_to_ascii_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.key_code    (key_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_valid  (char_valid),
		.char_value  (char_value),
		.power_off   (power_off),
		.dropped     (dropped),
		.shift_active(shift_active),
		.ctrl_active (ctrl_active),
		.caps_active (caps_active)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advances the expected keyboard state by one accepted transaction and returns
	// the result the block must produce for it.
	function automatic key_result_t apply_keystroke(input logic rt, input logic [7:0] code);
		key_result_t res;
		logic        use_shift;
		logic [7:0]  ch;
		res = '0;
		if (rt == REQ_READ) begin
			// The scan code field means nothing on a read.
			if (char_model.size() != 0) begin
				res.ch_ok = 1'b1;
				res.ch    = char_model.pop_front();
			end
		end else if (!code[7]) begin
			case (code)
				SC_ESC: res.poff = 1'b1;
				SC_LCTRL: lctrl_held = 1'b1;
				SC_LSHIFT: lshift_held = 1'b1;
				SC_RSHIFT: rshift_held = 1'b1;
				// Caps lock acts on its release, so its press is a no-op.
				SC_CAPS: ;
				SC_RCTRL: rctrl_held = 1'b1;
				default: begin
					// Shift and caps cancel each other out.
					use_shift = (lshift_held | rshift_held) ^ caps_on;
					if (code < KEY_COUNT) begin
						ch = use_shift ? SHIFTED_KEYS[code[5:0]] : PLAIN_KEYS[code[5:0]];
					end else begin
						ch = CHAR_SPACE;
					end
					if (char_model.size() >= FIFO_CAPACITY) begin
						res.drop = 1'b1;
					end else begin
						char_model.push_back(ch);
					end
				end
			endcase
		end else begin
			case (code)
				SC_LCTRL_REL: lctrl_held = 1'b0;
				SC_LSHIFT_REL: lshift_held = 1'b0;
				SC_RSHIFT_REL: rshift_held = 1'b0;
				SC_CAPS_REL: caps_on = ~caps_on;
				SC_RCTRL_REL: rctrl_held = 1'b0;
				default: ;
			endcase
		end
		res.shift = lshift_held | rshift_held;
		res.ctrl  = lctrl_held | rctrl_held;
		res.caps  = caps_on;
		return res;
	endfunction

	// Idle length for either channel: mostly none or short, now and then long.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_key(input logic rt, input logic [7:0] code);
		key_req_t k;
		k.rt   = rt;
		k.code = code;
		pending_keys.push_back(k);
	endfunction

	// One item of the mixed random traffic: reads, arbitrary presses, presses
	// within the keymap, modifier activity and arbitrary releases.
	function automatic void queue_random_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			queue_key(REQ_READ, 8'($urandom_range(0, 255)));
		end else if (r < 60) begin
			queue_key(REQ_SCAN, 8'($urandom_range(0, 127)));
		end else if (r < 75) begin
			queue_key(REQ_SCAN, 8'($urandom_range(2, KEY_COUNT - 1)));
		end else if (r < 90) begin
			queue_key(REQ_SCAN, MOD_CODES[$urandom_range(0, MOD_COUNT - 1)]);
		end else begin
			queue_key(REQ_SCAN, 8'($urandom_range(128, 255)));
		end
	endfunction

	task automatic flag_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $realtime, results_seen,
			field, got, want);
		error_count++;
	endtask

	// Driver. Each accepted transaction is run through the predictor at the edge
	// that accepts it. A new item is loaded only once the current one has been
	// taken, so valid never drops and the payload never changes while waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			req_type  <= REQ_SCAN;
			key_code  <= 8'h00;
			gap_left  <= 0;
			quiet_in  <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_keystroke(req_type, key_code));
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_keys.size() != 0) begin
					in_valid  <= 1'b1;
					req_type  <= pending_keys[0].rt;
					key_code  <= pending_keys[0].code;
					void'(pending_keys.pop_front());
					// During a quiet stretch items go back to back.
					if (quiet_in != 0) begin
						quiet_in <= quiet_in - 1;
					end else begin
						gap_left <= idle_length();
						if ($urandom_range(0, 99) < 3) begin
							quiet_in <= $urandom_range(20, 80);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result taken from the block is compared with the oldest
	// expectation; ready is stalled at random, with occasional stretches of none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			quiet_out  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("[%0t] result %0d arrived with nothing outstanding", $realtime,
						results_seen);
					error_count++;
				end else begin
					if (char_valid !== expected_results[0].ch_ok) begin
						flag_mismatch("char_valid", char_valid, expected_results[0].ch_ok);
					end
					if (char_value !== expected_results[0].ch) begin
						flag_mismatch("char_value", char_value, expected_results[0].ch);
					end
					if (power_off !== expected_results[0].poff) begin
						flag_mismatch("power_off", power_off, expected_results[0].poff);
					end
					if (dropped !== expected_results[0].drop) begin
						flag_mismatch("dropped", dropped, expected_results[0].drop);
					end
					if (shift_active !== expected_results[0].shift) begin
						flag_mismatch("shift_active", shift_active, expected_results[0].shift);
					end
					if (ctrl_active !== expected_results[0].ctrl) begin
						flag_mismatch("ctrl_active", ctrl_active, expected_results[0].ctrl);
					end
					if (caps_active !== expected_results[0].caps) begin
						flag_mismatch("caps_active", caps_active, expected_results[0].caps);
					end
					void'(expected_results.pop_front());
				end
				results_seen++;
			end
			if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (quiet_out != 0) begin
				out_ready <= 1'b1;
				quiet_out <= quiet_out - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 30) begin
					stall_left <= idle_length();
				end else if ($urandom_range(0, 99) < 4) begin
					quiet_out <= $urandom_range(20, 80);
				end
			end
		end
	end

	// Watchdog: a run in which neither channel moves for too long is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// Directed opening: empty read, unmapped codes at both ends of the make
		// range, escape, each modifier press and release, shift and caps lock
		// alone and together, caps lock press doing nothing, ignored releases.
		queue_key(REQ_READ, 8'hff);
		queue_key(REQ_SCAN, 8'h00);
		queue_key(REQ_SCAN, 8'h7f);
		queue_key(REQ_SCAN, SC_ESC);
		queue_key(REQ_SCAN, 8'h1e);             // 'a'
		queue_key(REQ_SCAN, SC_LSHIFT);
		queue_key(REQ_SCAN, 8'h1e);             // 'A'
		queue_key(REQ_SCAN, SC_RSHIFT);
		queue_key(REQ_SCAN, SC_LSHIFT_REL);
		queue_key(REQ_SCAN, 8'h02);             // '!' with right shift only
		queue_key(REQ_SCAN, SC_RSHIFT_REL);
		queue_key(REQ_SCAN, SC_CAPS);
		queue_key(REQ_SCAN, SC_CAPS_REL);       // caps lock turns on
		queue_key(REQ_SCAN, 8'h35);             // '?' from caps alone
		queue_key(REQ_SCAN, SC_LSHIFT);
		queue_key(REQ_SCAN, 8'h10);             // 'q': shift undoes caps
		queue_key(REQ_SCAN, SC_LSHIFT_REL);
		queue_key(REQ_SCAN, SC_LCTRL);
		queue_key(REQ_SCAN, SC_RCTRL);
		queue_key(REQ_SCAN, SC_LCTRL_REL);
		queue_key(REQ_SCAN, SC_RCTRL_REL);
		queue_key(REQ_SCAN, 8'h80);
		queue_key(REQ_SCAN, 8'hff);
		queue_key(REQ_SCAN, SC_CAPS_REL);       // caps lock turns off
		queue_key(REQ_READ, 8'h00);

		// Mixed traffic, then a burst of presses with no reads that must overflow
		// the FIFO, a run of reads that empties it completely, and mixed traffic
		// again with the pointers wrapped.
		repeat (250) queue_random_key();
		repeat (FIFO_DEPTH + 30) queue_key(REQ_SCAN, 8'($urandom_range(8'h10, 8'h19)));
		repeat (FIFO_DEPTH + 20) queue_key(REQ_READ, 8'($urandom_range(0, 255)));
		repeat (150) queue_random_key();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
		end while (pending_keys.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
